[sv/acex_pkg.sv]
// ----------------------------------------------------------------------------
// acex_pkg
// Shared types and operation codes for the accumulator CPU execute unit.
// ----------------------------------------------------------------------------
package acex_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [5:0] {
    F_NOP = 6'd0, F_LDA = 6'd1, F_LDX = 6'd2, F_LDY = 6'd3, F_STA = 6'd4,
    F_STX = 6'd5, F_STY = 6'd6, F_ORA = 6'd7, F_AND = 6'd8, F_EOR = 6'd9,
    F_ADC = 6'd10, F_SBC = 6'd11, F_CMP = 6'd12, F_CPX = 6'd13, F_CPY = 6'd14,
    F_BIT = 6'd15, F_ASLA = 6'd16, F_LSRA = 6'd17, F_ROLA = 6'd18, F_RORA = 6'd19,
    F_ASLM = 6'd20, F_LSRM = 6'd21, F_ROLM = 6'd22, F_RORM = 6'd23, F_INC = 6'd24,
    F_DEC = 6'd25, F_INX = 6'd26, F_DEX = 6'd27, F_INY = 6'd28, F_DEY = 6'd29,
    F_TAX = 6'd30, F_TXA = 6'd31, F_TAY = 6'd32, F_TYA = 6'd33, F_TSX = 6'd34,
    F_TXS = 6'd35, F_PHA = 6'd36, F_PHP = 6'd37, F_PLA = 6'd38, F_PLP = 6'd39,
    F_CLC = 6'd40, F_SEC = 6'd41, F_CLI = 6'd42, F_SEI = 6'd43, F_CLD = 6'd44,
    F_SED = 6'd45, F_CLV = 6'd46, F_BPL = 6'd47, F_BMI = 6'd48, F_BVC = 6'd49,
    F_BVS = 6'd50, F_BCC = 6'd51, F_BCS = 6'd52, F_BNE = 6'd53, F_BEQ = 6'd54,
    F_ILL = 6'd55
  } func_t;

  // classified instruction travelling from front to back
  typedef struct packed {
    func_t       func;
    logic [7:0]  operand;
    logic        extra_read;
    logic [15:0] pc_base;
  } instr_t;

  typedef struct packed {
    logic [7:0]  write_data;
    logic        write_enable;
    logic        stack_access;
    logic [8:0]  stack_address;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic        branch_taken;
    logic [15:0] next_pc;
    logic [1:0]  extra_cycles;
  } result_t;

  localparam logic [7:0] ResetSp     = 8'hFD;
  localparam logic [7:0] ResetStatus = 8'h24;

endpackage

[sv/acex_front.sv]
// ----------------------------------------------------------------------------
// acex_front
// Decode the function code and queue instructions for the back end.
// ----------------------------------------------------------------------------
module acex_front import acex_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  in_func,
  input  logic [7:0]  in_operand,
  input  logic        in_page_crossed,
  input  logic [15:0] in_pc_base,
  output logic        q_valid,
  input  logic        q_take,
  output instr_t      q_head
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  instr_t             mem_r [DEPTH];
  logic [AW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]        cnt_r, cnt_nxt;
  instr_t             cls;
  logic               wr, rd;

  always_comb begin
    cls.operand  = in_operand;
    cls.pc_base  = in_pc_base;
    cls.func     = (in_func > 6'd54) ? F_ILL : func_t'(in_func);
    unique case (cls.func)
      F_LDA, F_LDX, F_LDY, F_ORA, F_AND, F_EOR, F_ADC, F_SBC, F_CMP:
        cls.extra_read = in_page_crossed;
      default: cls.extra_read = 1'b0;
    endcase
  end

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign wr      = push && !full;
  assign rd      = q_take && q_valid;
  assign q_head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr ? ((wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = rd ? ((rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= cls;
    end
  end
endmodule

[sv/acex_back.sv]
// ----------------------------------------------------------------------------
// acex_back
// Execute queued instructions on the register file and hold the result.
// ----------------------------------------------------------------------------
module acex_back import acex_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_take,
  input  instr_t  q_head,
  output logic    empty,
  input  logic    pop,
  output result_t res
);
  logic [7:0] a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt, p_r, p_nxt;
  logic       ov_r;
  result_t    res_r, r;
  logic [7:0] m, zv, sh, cmpr, add_m;
  logic       setzn, c_out, bset;
  logic [8:0] sum, diff;
  logic [15:0] tgt;

  assign m      = q_head.operand;
  assign empty  = !ov_r;
  assign res    = res_r;
  assign q_take = q_valid && (!ov_r || pop);
  assign add_m  = (q_head.func == F_SBC) ? ~m : m;
  assign sum    = {1'b0, a_r} + {1'b0, add_m} + {8'd0, p_r[0]};
  assign tgt    = q_head.pc_base + {{8{m[7]}}, m};

  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; p_nxt = p_r;
    r = '0;
    zv = 8'd0; setzn = 1'b0; sh = 8'd0; c_out = 1'b0; bset = 1'b0;
    cmpr = a_r;
    r.next_pc = q_head.pc_base;
    unique case (q_head.func)
      F_ASLA, F_ROLA, F_LSRA, F_RORA: sh = a_r;
      default: sh = m;
    endcase
    unique case (q_head.func)
      F_ASLA, F_ASLM: begin c_out = sh[7]; sh = {sh[6:0], 1'b0}; end
      F_ROLA, F_ROLM: begin c_out = sh[7]; sh = {sh[6:0], p_r[0]}; end
      F_LSRA, F_LSRM: begin c_out = sh[0]; sh = {1'b0, sh[7:1]}; end
      F_RORA, F_RORM: begin c_out = sh[0]; sh = {p_r[0], sh[7:1]}; end
      default: ;
    endcase
    unique case (q_head.func)
      F_CPX:   cmpr = x_r;
      F_CPY:   cmpr = y_r;
      default: cmpr = a_r;
    endcase
    diff = {1'b0, cmpr} - {1'b0, m};
    unique case (q_head.func)
      F_BPL, F_BMI: bset = p_r[7];
      F_BVC, F_BVS: bset = p_r[6];
      F_BCC, F_BCS: bset = p_r[0];
      default:      bset = p_r[1];
    endcase
    unique case (q_head.func)
      F_LDA: begin a_nxt = m; zv = m; setzn = 1'b1; end
      F_LDX: begin x_nxt = m; zv = m; setzn = 1'b1; end
      F_LDY: begin y_nxt = m; zv = m; setzn = 1'b1; end
      F_STA: begin r.write_data = a_r; r.write_enable = 1'b1; end
      F_STX: begin r.write_data = x_r; r.write_enable = 1'b1; end
      F_STY: begin r.write_data = y_r; r.write_enable = 1'b1; end
      F_ORA: begin zv = a_r | m; a_nxt = zv; setzn = 1'b1; end
      F_AND: begin zv = a_r & m; a_nxt = zv; setzn = 1'b1; end
      F_EOR: begin zv = a_r ^ m; a_nxt = zv; setzn = 1'b1; end
      F_ADC, F_SBC: begin
        zv = sum[7:0]; a_nxt = zv; setzn = 1'b1;
        p_nxt[0] = sum[8];
        p_nxt[6] = ~(a_r[7] ^ add_m[7]) & (a_r[7] ^ sum[7]);
      end
      F_CMP, F_CPX, F_CPY: begin
        zv = diff[7:0]; setzn = 1'b1; p_nxt[0] = !diff[8];
      end
      F_BIT: begin
        p_nxt[1] = ((a_r & m) == 8'd0); p_nxt[7] = m[7]; p_nxt[6] = m[6];
      end
      F_ASLA, F_LSRA, F_ROLA, F_RORA: begin
        a_nxt = sh; zv = sh; setzn = 1'b1; p_nxt[0] = c_out;
      end
      F_ASLM, F_LSRM, F_ROLM, F_RORM: begin
        r.write_data = sh; r.write_enable = 1'b1; zv = sh; setzn = 1'b1;
        p_nxt[0] = c_out;
      end
      F_INC: begin zv = m + 8'd1; r.write_data = zv; r.write_enable = 1'b1; setzn = 1'b1; end
      F_DEC: begin zv = m - 8'd1; r.write_data = zv; r.write_enable = 1'b1; setzn = 1'b1; end
      F_INX: begin zv = x_r + 8'd1; x_nxt = zv; setzn = 1'b1; end
      F_DEX: begin zv = x_r - 8'd1; x_nxt = zv; setzn = 1'b1; end
      F_INY: begin zv = y_r + 8'd1; y_nxt = zv; setzn = 1'b1; end
      F_DEY: begin zv = y_r - 8'd1; y_nxt = zv; setzn = 1'b1; end
      F_TAX: begin x_nxt = a_r; zv = a_r; setzn = 1'b1; end
      F_TXA: begin a_nxt = x_r; zv = x_r; setzn = 1'b1; end
      F_TAY: begin y_nxt = a_r; zv = a_r; setzn = 1'b1; end
      F_TYA: begin a_nxt = y_r; zv = y_r; setzn = 1'b1; end
      F_TSX: begin x_nxt = sp_r; zv = sp_r; setzn = 1'b1; end
      F_TXS: sp_nxt = x_r;
      F_PHA, F_PHP: begin
        r.write_data   = (q_head.func == F_PHA) ? a_r : (p_r | 8'h30);
        r.write_enable = 1'b1;
        r.stack_access = 1'b1;
        r.stack_address = {1'b1, sp_r};
        sp_nxt = sp_r - 8'd1;
      end
      F_PLA, F_PLP: begin
        sp_nxt = sp_r + 8'd1;
        r.stack_access = 1'b1;
        r.stack_address = {1'b1, sp_nxt};
        if (q_head.func == F_PLA) begin
          a_nxt = m; zv = m; setzn = 1'b1;
        end else begin
          p_nxt = (m & 8'hEF) | 8'h20;
        end
      end
      F_CLC: p_nxt[0] = 1'b0;
      F_SEC: p_nxt[0] = 1'b1;
      F_CLI: p_nxt[2] = 1'b0;
      F_SEI: p_nxt[2] = 1'b1;
      F_CLD: p_nxt[3] = 1'b0;
      F_SED: p_nxt[3] = 1'b1;
      F_CLV: p_nxt[6] = 1'b0;
      F_BPL, F_BMI, F_BVC, F_BVS, F_BCC, F_BCS, F_BNE, F_BEQ: begin
        if (bset == (q_head.func[0] == 1'b0)) begin
          r.branch_taken = 1'b1;
          r.next_pc      = tgt;
          r.extra_cycles = (tgt[15:8] != q_head.pc_base[15:8]) ? 2'd2 : 2'd1;
        end
      end
      default: ;
    endcase
    if (setzn) begin
      p_nxt[1] = (zv == 8'd0);
      p_nxt[7] = zv[7];
    end
    if (q_head.extra_read) r.extra_cycles = 2'd1;
    if (!r.stack_access) r.stack_address = {1'b1, sp_nxt};
    r.acc_out = a_nxt; r.x_out = x_nxt; r.y_out = y_nxt;
    r.sp_out = sp_nxt; r.status_out = p_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; x_r <= '0; y_r <= '0; sp_r <= ResetSp; p_r <= ResetStatus;
      ov_r <= 1'b0;
    end else begin
      if (q_take) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; sp_r <= sp_nxt; p_r <= p_nxt;
        ov_r <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      res_r <= r;
    end
  end
endmodule

[sv/accumulator_cpu_execute_unit.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit
// Binary 6502-style instruction execute unit with queue handshakes.
// ----------------------------------------------------------------------------
// One instruction enters per cycle unless the queue is full. Each is stored in
// a queue entry and its result then in the result register, which the back end
// loads only when it is empty or being popped; its register file update is the
// loop that sets this rate. A two-entry queue between the decode front end and
// the execute back end holds new instructions while the previous result waits.
module accumulator_cpu_execute_unit import acex_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  in_func,
  input  logic [7:0]  in_operand,
  input  logic        in_page_crossed,
  input  logic [15:0] in_pc_base,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_write_data,
  output logic        out_write_enable,
  output logic        out_stack_access,
  output logic [8:0]  out_stack_address,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_x_out,
  output logic [7:0]  out_y_out,
  output logic [7:0]  out_sp_out,
  output logic [7:0]  out_status_out,
  output logic        out_branch_taken,
  output logic [15:0] out_next_pc,
  output logic [1:0]  out_extra_cycles
);
  logic    q_valid, q_take;
  instr_t  q_head;
  result_t res;

  acex_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .push, .full, .in_func, .in_operand, .in_page_crossed,
    .in_pc_base, .q_valid, .q_take, .q_head
  );

  acex_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_head, .empty, .pop, .res
  );

  assign out_write_data    = res.write_data;
  assign out_write_enable  = res.write_enable;
  assign out_stack_access  = res.stack_access;
  assign out_stack_address = res.stack_address;
  assign out_acc_out       = res.acc_out;
  assign out_x_out         = res.x_out;
  assign out_y_out         = res.y_out;
  assign out_sp_out        = res.sp_out;
  assign out_status_out    = res.status_out;
  assign out_branch_taken  = res.branch_taken;
  assign out_next_pc       = res.next_pc;
  assign out_extra_cycles  = res.extra_cycles;
endmodule

[sv/acex_checker.sv]
// ----------------------------------------------------------------------------
// acex_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module acex_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [8:0] out_stack_address,
  input logic       out_stack_access,
  input logic       out_write_enable,
  input logic [1:0] out_extra_cycles,
  input logic [7:0] out_status_out
);
  a_stack_page: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_stack_address[8]) else $error("stack address off page");
  a_unused_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_status_out[5]) else $error("unused status bit clear");
  a_extra_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_extra_cycles != 2'd3) else $error("extra cycles out of range");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> empty && !full) else $error("not idle after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_status_out) && $stable(out_stack_access)
    && $stable(out_write_enable)) else $error("result changed while held");
endmodule

bind accumulator_cpu_execute_unit acex_checker u_acex_checker (
  .clk, .rst_n, .full, .empty, .pop, .out_stack_address, .out_stack_access,
  .out_write_enable, .out_extra_cycles, .out_status_out
);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Instruction-level check of the accumulator CPU execute unit.
// Directed and random instructions are pushed through the input queue. A local
// model of the register file predicts each result, and every popped result is
// compared field by field with the oldest prediction. Both sides idle in random
// bursts, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_top import acex_pkg::*; ();

  localparam int unsigned NumRandom   = 1650;
  localparam int unsigned CalmTail    = 200;
  localparam int unsigned StallCycles = 60;
  localparam int unsigned IdleLimit   = 2000;

  localparam logic [7:0] FlagC = 8'h01;
  localparam logic [7:0] FlagZ = 8'h02;
  localparam logic [7:0] FlagI = 8'h04;
  localparam logic [7:0] FlagD = 8'h08;
  localparam logic [7:0] FlagB = 8'h10;
  localparam logic [7:0] FlagU = 8'h20;
  localparam logic [7:0] FlagV = 8'h40;
  localparam logic [7:0] FlagN = 8'h80;

  typedef struct packed {
    logic [5:0]  func;
    logic [7:0]  operand;
    logic        page_crossed;
    logic [15:0] pc_base;
  } insn_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [5:0]  in_func;
  logic [7:0]  in_operand;
  logic        in_page_crossed;
  logic [15:0] in_pc_base;
  logic        empty;
  logic        pop;
  result_t     got;

  insn_t   pending_insns[$];
  result_t expected_results[$];

  logic [7:0] m_acc, m_x, m_y, m_sp, m_status;

  int unsigned sent_count;
  int unsigned recv_count;
  int unsigned branch_taken_count;
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned stall_left;
  bit          stall_done;
  bit          stim_done;
  bit          calm;

  accumulator_cpu_execute_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_func           (in_func),
    .in_operand        (in_operand),
    .in_page_crossed   (in_page_crossed),
    .in_pc_base        (in_pc_base),
    .empty             (empty),
    .pop               (pop),
    .out_write_data    (got.write_data),
    .out_write_enable  (got.write_enable),
    .out_stack_access  (got.stack_access),
    .out_stack_address (got.stack_address),
    .out_acc_out       (got.acc_out),
    .out_x_out         (got.x_out),
    .out_y_out         (got.y_out),
    .out_sp_out        (got.sp_out),
    .out_status_out    (got.status_out),
    .out_branch_taken  (got.branch_taken),
    .out_next_pc       (got.next_pc),
    .out_extra_cycles  (got.extra_cycles)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void update_flag(logic [7:0] f, bit on);
    if (on) m_status = m_status | f;
    else m_status = m_status & ~f;
  endfunction

  function automatic logic [7:0] set_zn(logic [7:0] v);
    update_flag(FlagZ, v == 8'h00);
    update_flag(FlagN, v[7]);
    return v;
  endfunction

  function automatic void add_carry(logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, m_acc} + {1'b0, m} + {8'h00, m_status[0]};
    update_flag(FlagC, sum[8]);
    update_flag(FlagV, (~(m_acc[7] ^ m[7])) & (m_acc[7] ^ sum[7]));
    m_acc = set_zn(sum[7:0]);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    update_flag(FlagC, r >= m);
    void'(set_zn(r - m));
  endfunction

  function automatic logic [7:0] shift_byte(logic [1:0] kind, logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = m_status[0];
    case (kind)
      2'd0: begin update_flag(FlagC, v[7]); r = {v[6:0], 1'b0}; end
      2'd1: begin update_flag(FlagC, v[0]); r = {1'b0, v[7:1]}; end
      2'd2: begin update_flag(FlagC, v[7]); r = {v[6:0], cin}; end
      default: begin update_flag(FlagC, v[0]); r = {cin, v[7:1]}; end
    endcase
    return set_zn(r);
  endfunction

  function automatic result_t execute_insn(insn_t t);
    result_t    r;
    logic [7:0] m;
    logic [15:0] tgt;
    logic [7:0] sel;
    bit         is_read;
    int unsigned k;
    r = '0;
    m = t.operand;
    is_read = 1'b0;
    r.next_pc = t.pc_base;
    case (func_t'(t.func))
      F_LDA: begin m_acc = set_zn(m); is_read = 1'b1; end
      F_LDX: begin m_x = set_zn(m); is_read = 1'b1; end
      F_LDY: begin m_y = set_zn(m); is_read = 1'b1; end
      F_STA: begin r.write_data = m_acc; r.write_enable = 1'b1; end
      F_STX: begin r.write_data = m_x; r.write_enable = 1'b1; end
      F_STY: begin r.write_data = m_y; r.write_enable = 1'b1; end
      F_ORA: begin m_acc = set_zn(m_acc | m); is_read = 1'b1; end
      F_AND: begin m_acc = set_zn(m_acc & m); is_read = 1'b1; end
      F_EOR: begin m_acc = set_zn(m_acc ^ m); is_read = 1'b1; end
      F_ADC: begin add_carry(m); is_read = 1'b1; end
      F_SBC: begin add_carry(~m); is_read = 1'b1; end
      F_CMP: begin compare_reg(m_acc, m); is_read = 1'b1; end
      F_CPX: compare_reg(m_x, m);
      F_CPY: compare_reg(m_y, m);
      F_BIT: begin
        update_flag(FlagZ, (m_acc & m) == 8'h00);
        update_flag(FlagN, m[7]);
        update_flag(FlagV, m[6]);
      end
      F_ASLA, F_LSRA, F_ROLA, F_RORA: m_acc = shift_byte(t.func[1:0], m_acc);
      F_ASLM, F_LSRM, F_ROLM, F_RORM: begin
        r.write_data = shift_byte(2'(t.func - 6'd20), m);
        r.write_enable = 1'b1;
      end
      F_INC: begin r.write_data = set_zn(m + 8'd1); r.write_enable = 1'b1; end
      F_DEC: begin r.write_data = set_zn(m - 8'd1); r.write_enable = 1'b1; end
      F_INX: m_x = set_zn(m_x + 8'd1);
      F_DEX: m_x = set_zn(m_x - 8'd1);
      F_INY: m_y = set_zn(m_y + 8'd1);
      F_DEY: m_y = set_zn(m_y - 8'd1);
      F_TAX: m_x = set_zn(m_acc);
      F_TXA: m_acc = set_zn(m_x);
      F_TAY: m_y = set_zn(m_acc);
      F_TYA: m_acc = set_zn(m_y);
      F_TSX: m_x = set_zn(m_sp);
      F_TXS: m_sp = m_x;
      F_PHA, F_PHP: begin
        r.write_data = (t.func == F_PHA) ? m_acc : (m_status | FlagB | FlagU);
        r.write_enable = 1'b1;
        r.stack_access = 1'b1;
        r.stack_address = {1'b1, m_sp};
        m_sp = m_sp - 8'd1;
      end
      F_PLA, F_PLP: begin
        m_sp = m_sp + 8'd1;
        r.stack_access = 1'b1;
        r.stack_address = {1'b1, m_sp};
        if (t.func == F_PLA) m_acc = set_zn(m);
        else m_status = (m & ~FlagB) | FlagU;
      end
      F_CLC: update_flag(FlagC, 1'b0);
      F_SEC: update_flag(FlagC, 1'b1);
      F_CLI: update_flag(FlagI, 1'b0);
      F_SEI: update_flag(FlagI, 1'b1);
      F_CLD: update_flag(FlagD, 1'b0);
      F_SED: update_flag(FlagD, 1'b1);
      F_CLV: update_flag(FlagV, 1'b0);
      F_BPL, F_BMI, F_BVC, F_BVS, F_BCC, F_BCS, F_BNE, F_BEQ: begin
        k = t.func - F_BPL;
        case ((k >> 1) & 3)
          0: sel = FlagN;
          1: sel = FlagV;
          2: sel = FlagC;
          default: sel = FlagZ;
        endcase
        if (((m_status & sel) != 8'h00) == k[0]) begin
          tgt = t.pc_base + {{8{m[7]}}, m};
          r.branch_taken = 1'b1;
          r.next_pc = tgt;
          r.extra_cycles = (tgt[15:8] != t.pc_base[15:8]) ? 2'd2 : 2'd1;
        end
      end
      default: ;
    endcase
    if (is_read && t.page_crossed) r.extra_cycles = 2'd1;
    if (!r.stack_access) r.stack_address = {1'b1, m_sp};
    r.acc_out = m_acc;
    r.x_out = m_x;
    r.y_out = m_y;
    r.sp_out = m_sp;
    r.status_out = m_status;
    return r;
  endfunction

  function automatic insn_t rand_insn(logic [5:0] f);
    insn_t t;
    t.func = f;
    t.operand = 8'($urandom);
    t.page_crossed = 1'($urandom);
    t.pc_base = 16'($urandom);
    return t;
  endfunction

  function automatic void add_insn(logic [5:0] f, logic [7:0] op, logic pc,
                                   logic [15:0] pca);
    insn_t t;
    t.func = f;
    t.operand = op;
    t.page_crossed = pc;
    t.pc_base = pca;
    pending_insns.push_back(t);
  endfunction

  initial begin
    int unsigned sel;
    m_acc = 8'h00;
    m_x = 8'h00;
    m_y = 8'h00;
    m_sp = ResetSp;
    m_status = ResetStatus;
    add_insn(F_LDA, 8'h00, 1'b1, 16'h0000);
    add_insn(F_LDA, 8'hFF, 1'b0, 16'hFFFF);
    add_insn(F_ADC, 8'h01, 1'b1, 16'h1234);
    add_insn(F_LDA, 8'h7F, 1'b0, 16'h0000);
    add_insn(F_ADC, 8'h01, 1'b0, 16'h0000);
    add_insn(F_SBC, 8'h80, 1'b1, 16'h0000);
    add_insn(F_CPX, 8'h00, 1'b1, 16'h0000);
    add_insn(F_BIT, 8'hC0, 1'b1, 16'h0000);
    add_insn(F_PHP, 8'h00, 1'b0, 16'h0000);
    add_insn(F_PLP, 8'hFF, 1'b0, 16'h0000);
    add_insn(F_TSX, 8'h00, 1'b0, 16'h0000);
    add_insn(F_LDX, 8'h00, 1'b0, 16'h0000);
    add_insn(F_TXS, 8'h00, 1'b0, 16'h0000);
    add_insn(F_PLA, 8'h80, 1'b0, 16'h0000);
    add_insn(F_PHA, 8'h00, 1'b0, 16'h0000);
    add_insn(F_STA, 8'h00, 1'b1, 16'h0000);
    add_insn(F_INC, 8'hFF, 1'b1, 16'h0000);
    add_insn(F_RORM, 8'h01, 1'b1, 16'h0000);
    add_insn(F_BNE, 8'h7F, 1'b0, 16'h00F0);
    add_insn(F_BEQ, 8'h80, 1'b0, 16'h0010);
    add_insn(F_BPL, 8'h80, 1'b0, 16'h0000);
    add_insn(F_CLV, 8'h00, 1'b0, 16'h0000);
    add_insn(6'd63, 8'hFF, 1'b1, 16'hFFFF);
    add_insn(F_ILL, 8'h00, 1'b0, 16'h0000);
    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) pending_insns.push_back(rand_insn(6'($urandom)));
      else if (sel < 3)
        pending_insns.push_back(rand_insn(6'($urandom_range(F_BPL, F_BEQ))));
      else if (sel < 4)
        pending_insns.push_back(rand_insn(6'($urandom_range(F_CLC, F_CLV))));
      else pending_insns.push_back(rand_insn(6'($urandom_range(F_NOP, F_PLP))));
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_func <= '0;
      in_operand <= '0;
      in_page_crossed <= 1'b0;
      in_pc_base <= '0;
      send_gap <= 0;
    end else begin
      logic fire;
      fire = push && !full;
      if (fire) begin
        expected_results.push_back(execute_insn({in_func, in_operand, in_page_crossed,
                                                 in_pc_base}));
        sent_count <= sent_count + 1;
      end
      if (push && !fire) begin
      end else if (send_gap != 0) begin
        push <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_insns.size() != 0 && !(!calm && $urandom_range(0, 7) == 0)) begin
        insn_t t;
        t = pending_insns.pop_front();
        push <= 1'b1;
        in_func <= t.func;
        in_operand <= t.operand;
        in_page_crossed <= t.page_crossed;
        in_pc_base <= t.pc_base;
      end else begin
        push <= 1'b0;
        if (!calm && pending_insns.size() != 0) send_gap <= $urandom_range(0, 6);
      end
    end
  end

  assign calm = pending_insns.size() < CalmTail;

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      recv_gap <= 0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else begin
      if (pop && !empty) begin
        result_t e;
        recv_count <= recv_count + 1;
        if (got.branch_taken) branch_taken_count <= branch_taken_count + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction");
          error_count <= error_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (got !== e) begin
            error_count <= error_count + 1;
            if (got.write_data !== e.write_data)
              $error("write_data exp %0h got %0h", e.write_data, got.write_data);
            if (got.write_enable !== e.write_enable)
              $error("write_enable exp %0h got %0h", e.write_enable, got.write_enable);
            if (got.stack_access !== e.stack_access)
              $error("stack_access exp %0h got %0h", e.stack_access, got.stack_access);
            if (got.stack_address !== e.stack_address)
              $error("stack_address exp %0h got %0h", e.stack_address,
                     got.stack_address);
            if (got.acc_out !== e.acc_out)
              $error("acc_out exp %0h got %0h", e.acc_out, got.acc_out);
            if (got.x_out !== e.x_out)
              $error("x_out exp %0h got %0h", e.x_out, got.x_out);
            if (got.y_out !== e.y_out)
              $error("y_out exp %0h got %0h", e.y_out, got.y_out);
            if (got.sp_out !== e.sp_out)
              $error("sp_out exp %0h got %0h", e.sp_out, got.sp_out);
            if (got.status_out !== e.status_out)
              $error("status_out exp %0h got %0h", e.status_out, got.status_out);
            if (got.branch_taken !== e.branch_taken)
              $error("branch_taken exp %0h got %0h", e.branch_taken, got.branch_taken);
            if (got.next_pc !== e.next_pc)
              $error("next_pc exp %0h got %0h", e.next_pc, got.next_pc);
            if (got.extra_cycles !== e.extra_cycles)
              $error("extra_cycles exp %0h got %0h", e.extra_cycles, got.extra_cycles);
          end
        end
      end
      if (!stall_done && sent_count > 100) begin
        stall_done <= 1'b1;
        stall_left <= StallCycles;
        pop <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        pop <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_func = '0;
    in_operand = '0;
    in_page_crossed = 1'b0;
    in_pc_base = '0;
    sent_count = 0;
    recv_count = 0;
    branch_taken_count = 0;
    error_count = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_insns.size() == 0 && !push);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("Executed %0d instructions, checked %0d results, %0d branches taken.",
             sent_count, recv_count, branch_taken_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[accumulator_cpu_execute_unit.f]
sv/acex_pkg.sv
sv/acex_front.sv
sv/acex_back.sv
sv/accumulator_cpu_execute_unit.sv
sv/acex_checker.sv
sim/tb_top.sv
